// ===== src/h3e_pkg.sv =====
`default_nettype none

package h3e_pkg;

   localparam int AXIS_BITS   = 16;
   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 48;
   localparam int TDATA_IN_W  = 3 * COORD_W;
   localparam int TDATA_OUT_W = ((INDEX_W + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 3;
   localparam int AXIS_MAX    = (1 << AXIS_BITS) - 1;

   localparam int LEVELS_PER_STAGE = 2;
   localparam int UNDO_STAGES      = (AXIS_BITS - 1 + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;

   localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0001_0000;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

   typedef logic [2:0][COORD_W-1:0]   triple_type;
   typedef logic [2:0][AXIS_BITS-1:0] axes_type;

   typedef struct packed {
      triple_type origin;
      triple_type scale;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      logic     oob;
      axes_type axes;
   } point_type;

   typedef struct packed {
      logic               valid;
      logic               oob;
      logic [INDEX_W-1:0] index;
   } rsp_type;

   // one invert/exchange level of the undo pass, bit lvl of every axis
   function automatic axes_type undo_level(input axes_type a_in, input int lvl);
      axes_type             a;
      logic [AXIS_BITS-1:0] low;
      logic [AXIS_BITS-1:0] sw;
      a   = a_in;
      low = AXIS_BITS'((1 << lvl) - 1);
      for (int i = 0; i < 3; i++) begin
         if (a[i][lvl]) begin
            a[0] = a[0] ^ low;
         end else begin
            sw   = (a[0] ^ a[i]) & low;
            a[0] = a[0] ^ sw;
            a[i] = a[i] ^ sw;
         end
      end
      return a;
   endfunction

   function automatic logic [INDEX_W-1:0] gray_key(input axes_type a_in);
      axes_type               a;
      logic [AXIS_BITS-1:0]   flip;
      logic [3*AXIS_BITS-1:0] key;
      a    = a_in;
      a[1] = a[1] ^ a[0];
      a[2] = a[2] ^ a[1];
      for (int j = 0; j < AXIS_BITS; j++) begin
         flip[j] = ^(a[2] >> (j + 1));
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] ^ flip;
      end
      for (int b = 0; b < AXIS_BITS; b++) begin
         for (int i = 0; i < 3; i++) begin
            key[3 * b + 2 - i] = a[i][b];
         end
      end
      return INDEX_W'(key);
   endfunction

endpackage

`default_nettype wire

// ===== src/h3e_quant.sv =====
`default_nettype none

module h3e_quant (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire h3e_pkg::triple_type coord,
   input  wire h3e_pkg::cfg_type    cfg,
   output h3e_pkg::point_type       point
);
   import h3e_pkg::*;

   logic       valid1_ff, valid2_ff;
   logic [2:0] neg1_ff, zero1_ff, neg2_ff, zero2_ff;
   triple_type mag1_ff, scale1_ff, whole2_ff;
   triple_type mag1_in, whole2_in;
   logic [2:0] neg1_in, zero1_in;
   point_type  point_ff, point_in;

   logic [COORD_W:0]     diff   [3];
   logic [2*COORD_W-1:0] prod   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]     = {coord[i][COORD_W-1], coord[i]} - {cfg.origin[i][COORD_W-1], cfg.origin[i]};
         neg1_in[i]  = diff[i][COORD_W];
         mag1_in[i]  = diff[i][COORD_W-1:0];
         zero1_in[i] = (cfg.scale[i] == '0);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]      = (2*COORD_W)'(mag1_ff[i]) * (2*COORD_W)'(scale1_ff[i]);
         whole2_in[i] = prod[i][2*COORD_W-1:COORD_W];
      end
   end

   always_comb begin
      point_in.valid = valid2_ff;
      point_in.oob   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (zero2_ff[i]) begin
            point_in.axes[i] = '0;
         end else if (neg2_ff[i]) begin
            point_in.axes[i] = '0;
            point_in.oob     = 1'b1;
         end else if (whole2_ff[i] > COORD_W'(AXIS_MAX)) begin
            point_in.axes[i] = '1;
            point_in.oob     = 1'b1;
         end else begin
            point_in.axes[i] = whole2_ff[i][AXIS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff      <= 1'b0;
         valid2_ff      <= 1'b0;
         point_ff.valid <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         neg1_ff   <= neg1_in;
         zero1_ff  <= zero1_in;
         mag1_ff   <= mag1_in;
         scale1_ff <= cfg.scale;
         valid2_ff <= valid1_ff;
         neg2_ff   <= neg1_ff;
         zero2_ff  <= zero1_ff;
         whole2_ff <= whole2_in;
         point_ff  <= point_in;
      end
   end

   assign point = point_ff;

endmodule

`default_nettype wire

// ===== src/h3e_undo.sv =====
`default_nettype none

module h3e_undo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire h3e_pkg::point_type in_point,
   output h3e_pkg::point_type      out_point
);
   import h3e_pkg::*;

   point_type stage_ff [UNDO_STAGES];

   for (genvar s = 0; s < UNDO_STAGES; s++) begin : g_stage
      point_type src;
      point_type stage_in;

      if (s == 0) begin : g_head
         assign src = in_point;
      end else begin : g_tail
         assign src = stage_ff[s-1];
      end

      always_comb begin
         int lvl;
         stage_in = src;
         for (int k = 0; k < LEVELS_PER_STAGE; k++) begin
            lvl = AXIS_BITS - 1 - (s * LEVELS_PER_STAGE + k);
            if (lvl >= 1) begin
               stage_in.axes = undo_level(stage_in.axes, lvl);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (en) begin
            stage_ff[s] <= stage_in;
         end
      end
   end

   assign out_point = stage_ff[UNDO_STAGES-1];

endmodule

`default_nettype wire

// ===== src/h3e_gray.sv =====
`default_nettype none

module h3e_gray (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire h3e_pkg::point_type in_point,
   output h3e_pkg::rsp_type        rsp
);
   import h3e_pkg::*;

   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.valid = in_point.valid;
      rsp_in.oob   = in_point.oob;
      rsp_in.index = gray_key(in_point.axes);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ===== src/hilbert_3d_encode.sv =====
`default_nettype none

// channel | dir | word
// req_    | in  | tdata: coord_x, coord_y, coord_z (32 each, signed Q16.16)
// rsp_    | out | tdata: curve_index (48); tuser: out_of_box
// csr_    | in  | we, index 0..5, wdata (32)
//
// One word per cycle while rsp_ is not held; the pipe is three quantize
// stages, one stage per two undo levels, then one gray/output stage.
// Reset clears every stage valid and loads the register defaults.
// A held rsp_ word freezes the whole pipe and drops req_tready.
module hilbert_3d_encode (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [h3e_pkg::TDATA_IN_W-1:0]  req_tdata,   // coord_x, coord_y, coord_z
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [h3e_pkg::TDATA_OUT_W-1:0]      rsp_tdata,   // curve_index
   output logic                                 rsp_tuser,   // out_of_box
   input  wire logic                            csr_we,
   input  wire logic [h3e_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [h3e_pkg::COORD_W-1:0]     csr_wdata
);
   import h3e_pkg::*;

   cfg_type    cfg_ff;
   triple_type coord;
   point_type  q_point, u_point;
   rsp_type    rsp;
   logic       en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.scale  <= {SCALE_RESET, SCALE_RESET, SCALE_RESET};
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: cfg_ff.origin[0] <= csr_wdata;
            REG_ORIGIN_Y: cfg_ff.origin[1] <= csr_wdata;
            REG_ORIGIN_Z: cfg_ff.origin[2] <= csr_wdata;
            REG_SCALE_X:  cfg_ff.scale[0]  <= csr_wdata;
            REG_SCALE_Y:  cfg_ff.scale[1]  <= csr_wdata;
            REG_SCALE_Z:  cfg_ff.scale[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign coord[0] = req_tdata[COORD_W-1:0];
   assign coord[1] = req_tdata[2*COORD_W-1:COORD_W];
   assign coord[2] = req_tdata[3*COORD_W-1:2*COORD_W];

   // advance while the output slot is empty or being taken
   assign en         = !rsp.valid || rsp_tready;
   assign req_tready = en;

   h3e_quant u_quant (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .coord    (coord),
      .cfg      (cfg_ff),
      .point    (q_point)
   );

   h3e_undo u_undo (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_point  (q_point),
      .out_point (u_point)
   );

   h3e_gray u_gray (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_point (u_point),
      .rsp      (rsp)
   );

   assign rsp_tvalid = rsp.valid;
   assign rsp_tdata  = TDATA_OUT_W'(rsp.index);
   assign rsp_tuser  = rsp.oob;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_clamp_edge : assert property (@(posedge clock) disable iff (reset)
      (q_point.valid && q_point.oob) |->
         (q_point.axes[0] == '0 || q_point.axes[0] == '1 ||
          q_point.axes[1] == '0 || q_point.axes[1] == '1 ||
          q_point.axes[2] == '0 || q_point.axes[2] == '1))
      else $error("clamp flag without a clamped axis");

endmodule

`default_nettype wire
